// ===== rtl/crd_pkg.sv =====
// Shared types and widths for the camera ray direction color block.
// No dependencies; every other file in rtl/ imports this package.
package crd_pkg;

  // coordinate width of inputs and image size registers
  localparam int CW   = 12;
  // signed direction component: 2*p - w spans one bit more plus sign
  localparam int DW   = CW + 2;
  // magnitude of a direction component
  localparam int MW   = CW + 1;
  // square of one component
  localparam int SQW  = 2 * MW;
  // sum of three squares
  localparam int S2W  = SQW + 2;
  // color digit width
  localparam int KW   = 8;
  // 255 * |d|
  localparam int PW   = MW + KW;
  // (255 * d)^2
  localparam int TW   = 2 * PW;
  // k * s2 and k^2 * s2 accumulators
  localparam int KSW  = S2W + KW;
  localparam int KQW  = S2W + 2 * KW + 1;
  // full-scale color value
  localparam int COLOR_MAX = 255;

  // pipeline depth: four arithmetic stages plus one per color bit
  localparam int FRONT_STAGES = 4;
  localparam int DEPTH        = FRONT_STAGES + KW;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic [CW-1:0]  coord_t;
  typedef logic [S2W-1:0] norm_t;
  typedef logic [TW-1:0]  target_t;
  typedef logic [KW-1:0]  color_t;

endpackage

// ===== rtl/crd_search.sv =====
// Eight-stage bit-by-bit search for the largest k with k*k*s2 <= target.
// Depends on crd_pkg. k^2*s2 and k*s2 are carried forward so no stage multiplies.
module crd_search (
  input  logic             clk,
  input  logic             en,
  input  crd_pkg::norm_t   s2,
  input  crd_pkg::target_t target,
  input  logic             pos,
  output crd_pkg::color_t  k
);
  import crd_pkg::*;

  // stage registers, stage i+1 holds the result of search step i
  logic [KQW-1:0] ksq  [1:KW];
  logic [KSW-1:0] ks   [1:KW];
  logic [KW-1:0]  kk   [1:KW];
  norm_t          s2p  [1:KW];
  target_t        tgt  [1:KW];
  logic           posp [1:KW];

  // inputs of each search step
  logic [KQW-1:0] ksq_in  [0:KW-1];
  logic [KSW-1:0] ks_in   [0:KW-1];
  logic [KW-1:0]  kk_in   [0:KW-1];
  norm_t          s2_in   [0:KW-1];
  target_t        tgt_in  [0:KW-1];
  logic           pos_in  [0:KW-1];

  logic [KQW-1:0] cand     [0:KW-1];
  logic           take     [0:KW-1];
  logic [KQW-1:0] ksq_next [0:KW-1];
  logic [KSW-1:0] ks_next  [0:KW-1];
  logic [KW-1:0]  kk_next  [0:KW-1];

  // step zero starts from k = 0 with the front pipeline values
  always_comb begin
    ksq_in[0] = '0;
    ks_in[0]  = '0;
    kk_in[0]  = '0;
    s2_in[0]  = s2;
    tgt_in[0] = target;
    pos_in[0] = pos;
    for (int i = 1; i < KW; i++) begin
      ksq_in[i] = ksq[i];
      ks_in[i]  = ks[i];
      kk_in[i]  = kk[i];
      s2_in[i]  = s2p[i];
      tgt_in[i] = tgt[i];
      pos_in[i] = posp[i];
    end
  end

  // try bit (KW-1-i) in stage i: (k+b)^2*s2 = k^2*s2 + 2b*k*s2 + b^2*s2
  always_comb begin
    for (int i = 0; i < KW; i++) begin
      cand[i] = ksq_in[i] + (KQW'(ks_in[i]) << (KW - i))
                + (KQW'(s2_in[i]) << (2 * (KW - 1 - i)));
      take[i] = cand[i] <= KQW'(tgt_in[i]);
      ksq_next[i] = take[i] ? cand[i] : ksq_in[i];
      ks_next[i]  = take[i] ? ks_in[i] + (KSW'(s2_in[i]) << (KW - 1 - i)) : ks_in[i];
      kk_next[i]  = take[i] ? (kk_in[i] | (KW'(1) << (KW - 1 - i))) : kk_in[i];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < KW; i++) begin
        ksq[i+1]  <= ksq_next[i];
        ks[i+1]   <= ks_next[i];
        kk[i+1]   <= kk_next[i];
        s2p[i+1]  <= s2_in[i];
        tgt[i+1]  <= tgt_in[i];
        posp[i+1] <= pos_in[i];
      end
    end
  end

  // non-positive component gives zero
  assign k = posp[KW] ? kk[KW] : '0;

endmodule

// ===== rtl/camera_ray_direction_color.sv =====
// Pinhole camera ray color: top level with config registers and front pipeline.
// Depends on crd_pkg and crd_search.
//
// Takes one pixel (pixel_x, pixel_y) per clock unless stalled and returns the color
// of the unit ray direction (2x-W, H-2y, -H): red and green are floor(255*d/|D|) for
// positive components, zero otherwise; blue is always zero. Throughput is one
// transaction per clock unless stalled: four stages form the direction, squares,
// norm and target, then one stage per color bit runs the root search. in_stall is
// high exactly while a result is held with out_stall high; the whole pipeline then
// freezes. Write image_width/image_height only while idle.
module camera_ray_direction_color (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  crd_pkg::reg_index_t  cfg_index,
  input  crd_pkg::coord_t      cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crd_pkg::coord_t      pixel_x,
  input  crd_pkg::coord_t      pixel_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crd_pkg::color_t      red,
  output crd_pkg::color_t      green,
  output crd_pkg::color_t      blue
);
  import crd_pkg::*;

  coord_t image_width;
  coord_t image_height;

  logic              en;
  logic [DEPTH-1:0]  vld;

  // stage 0
  logic signed [DW-1:0] dx0, dy0;
  logic [MW-1:0]        hz0;
  // stage 1
  logic [SQW-1:0] sqx1, sqy1, sqz1;
  logic [MW-1:0]  magx1, magy1;
  logic           posx1, posy1;
  logic [MW-1:0]  magx_c, magy_c;
  // stage 2
  norm_t          s2_2;
  logic [PW-1:0]  px2, py2;
  logic           posx2, posy2;
  // stage 3
  norm_t          s2_3;
  target_t        tx3, ty3;
  logic           posx3, posy3;

  // whole pipeline advances unless the held result is stalled
  assign en       = !(vld[DEPTH-1] && out_stall);
  assign in_stall = !en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CW'(1920);
      image_height <= CW'(1080);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  assign magx_c = dx0[DW-1] ? MW'(-dx0) : MW'(dx0);
  assign magy_c = dy0[DW-1] ? MW'(-dy0) : MW'(dy0);

  // front arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      // direction
      dx0 <= $signed({1'b0, pixel_x, 1'b0}) - $signed({2'b00, image_width});
      dy0 <= $signed({2'b00, image_height}) - $signed({1'b0, pixel_y, 1'b0});
      hz0 <= MW'(image_height);
      // squares
      sqx1  <= SQW'(magx_c) * SQW'(magx_c);
      sqy1  <= SQW'(magy_c) * SQW'(magy_c);
      sqz1  <= SQW'(hz0) * SQW'(hz0);
      magx1 <= magx_c;
      magy1 <= magy_c;
      posx1 <= !dx0[DW-1] && (dx0 != '0);
      posy1 <= !dy0[DW-1] && (dy0 != '0);
      // norm squared and scaled components
      s2_2  <= S2W'(sqx1) + S2W'(sqy1) + S2W'(sqz1);
      px2   <= PW'(magx1) * PW'(COLOR_MAX);
      py2   <= PW'(magy1) * PW'(COLOR_MAX);
      posx2 <= posx1;
      posy2 <= posy1;
      // search targets
      s2_3  <= s2_2;
      tx3   <= TW'(px2) * TW'(px2);
      ty3   <= TW'(py2) * TW'(py2);
      posx3 <= posx2;
      posy3 <= posy2;
    end
  end

  crd_search u_red (
    .clk    (clk),
    .en     (en),
    .s2     (s2_3),
    .target (tx3),
    .pos    (posx3),
    .k      (red)
  );

  crd_search u_green (
    .clk    (clk),
    .en     (en),
    .s2     (s2_3),
    .target (ty3),
    .pos    (posy3),
    .k      (green)
  );

  // z component is -H, never positive
  assign blue      = '0;
  assign out_valid = vld[DEPTH-1];

  // checks
  a_blue_zero: assert property (@(posedge clk) disable iff (rst) blue == '0)
    else $error("blue must be zero");
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");
  a_valid_shift: assert property (@(posedge clk) disable iff (rst)
    en |=> out_valid == $past(vld[DEPTH-2]))
    else $error("valid bit lost or invented in pipeline");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> out_valid && $stable(red) && $stable(green))
    else $error("frozen pipeline changed its result");

endmodule
